[rtl/core/firmware_image_crc_checker_assert.svh]
// assertion macros used by the checker file
`ifndef FIRMWARE_IMAGE_CRC_CHECKER_ASSERT_SVH
`define FIRMWARE_IMAGE_CRC_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define FIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fic_pkg.sv]
// shared types, constants and crc table for the firmware image crc checker
`timescale 1ns / 1ps

package fic_pkg;

    // image header layout and crc constants
    localparam logic [31:0] IMG_MAGIC   = 32'h3052_4448;
    localparam logic [31:0] HDR_SIZE    = 32'd28;
    localparam logic [31:0] HDR_LAST    = 32'd27;
    localparam logic [31:0] CRC_START   = 32'd12;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    // header field offsets, low five bits of the byte position
    localparam logic [4:0] OFS_LENGTH   = 5'd4;
    localparam logic [4:0] OFS_HCRC     = 5'd8;
    localparam logic [4:0] OFS_FLAGS    = 5'd12;
    localparam logic [4:0] OFS_VER_LO   = 5'd14;
    localparam logic [4:0] OFS_VER_HI   = 5'd15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_IMAGE,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_VALID,
        ST_SHORT_HDR,
        ST_BAD_MAGIC,
        ST_LEN_LOW,
        ST_SHORT_DATA,
        ST_CRC_BAD
    } t_status;

    // one status report
    typedef struct packed {
        t_status     status;
        logic [15:0] version;
        logic [31:0] crc;
        logic [31:0] length;
    } t_result;

    // reflected crc-32 table entry for one index byte
    function automatic logic [31:0] crc_tbl(input logic [7:0] idx);
        logic [31:0] c;
        c = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/fic_crc.sv]
// table-driven reflected crc-32 update for one byte
`timescale 1ns / 1ps

module fic_crc (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);
    import fic_pkg::*;

    // shift out one byte and fold in the table entry
    assign o_crc = {8'd0, i_crc[31:8]} ^ crc_tbl(i_crc[7:0] ^ i_byte);

endmodule

[rtl/core/fic_parse.sv]
// stream state, header capture, crc register and status decision
`timescale 1ns / 1ps

module fic_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_sos,
    input  logic             i_eos,
    input  logic [31:0]      i_skip_bytes,
    output logic             o_emit,
    output fic_pkg::t_result o_result
);
    import fic_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    logic [31:0] r_pos, n_pos, c_pos;
    logic [31:0] r_magic, n_magic, c_magic;
    logic [31:0] r_length, n_length, c_length;
    logic [31:0] r_hcrc, n_hcrc, c_hcrc;
    logic [15:0] r_version, n_version, c_version;
    logic [31:0] r_crc, n_crc, c_crc;
    logic [31:0] crc_upd;
    logic [31:0] pos_inc;
    logic [31:0] p;
    logic        img_go;
    logic        hdr_ok;
    logic        crc_ok;
    t_status     status;

    // state as seen by this request, a start mark clears it
    always_comb begin
        c_phase   = r_phase;
        c_pos     = r_pos;
        c_magic   = r_magic;
        c_length  = r_length;
        c_hcrc    = r_hcrc;
        c_version = r_version;
        c_crc     = r_crc;
        if (i_sos) begin
            c_phase   = PH_SKIP;
            c_pos     = '0;
            c_magic   = '0;
            c_length  = '0;
            c_hcrc    = '0;
            c_version = '0;
            c_crc     = CRC_PRESET;
        end
    end

    fic_crc u_crc (
        .i_crc  (c_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    assign pos_inc = c_pos + 32'd1;
    assign crc_ok  = (crc_upd == c_hcrc);

    // next state and decision
    always_comb begin
        n_phase   = c_phase;
        n_pos     = c_pos;
        n_magic   = c_magic;
        n_length  = c_length;
        n_hcrc    = c_hcrc;
        n_version = c_version;
        n_crc     = c_crc;
        o_emit    = 1'b0;
        status    = ST_VALID;
        hdr_ok    = 1'b0;
        img_go    = 1'b0;
        p         = c_pos;

        case (c_phase)
            PH_SKIP: begin
                if (c_pos < i_skip_bytes) begin
                    if (pos_inc == i_skip_bytes) begin
                        n_phase = PH_IMAGE;
                        n_pos   = '0;
                    end else begin
                        n_pos = pos_inc;
                    end
                    if (i_eos) begin
                        o_emit = 1'b1;
                        status = ST_SHORT_HDR;
                    end
                end else begin
                    n_phase = PH_IMAGE;
                    img_go  = 1'b1;
                    p       = '0;
                end
            end
            PH_IMAGE: begin
                img_go = 1'b1;
            end
            default: begin
            end
        endcase

        if (img_go) begin
            if (p < HDR_SIZE) begin
                // header capture, little endian
                if (p[4:0] < OFS_LENGTH) begin
                    n_magic[{p[1:0], 3'b000} +: 8] = i_byte;
                end else if (p[4:0] < OFS_HCRC) begin
                    n_length[{p[1:0], 3'b000} +: 8] = i_byte;
                end else if (p[4:0] < OFS_FLAGS) begin
                    n_hcrc[{p[1:0], 3'b000} +: 8] = i_byte;
                end else if (p[4:0] == OFS_VER_LO) begin
                    n_version[7:0] = i_byte;
                end else if (p[4:0] == OFS_VER_HI) begin
                    n_version[15:8] = i_byte;
                end
                if (p >= CRC_START) begin
                    n_crc = crc_upd;
                end
                if (p == HDR_LAST) begin
                    // header complete: checks in priority order
                    hdr_ok = 1'b1;
                    n_pos  = p + 32'd1;
                    if (c_magic != IMG_MAGIC) begin
                        o_emit = 1'b1;
                        status = ST_BAD_MAGIC;
                    end else if (c_length < HDR_SIZE) begin
                        o_emit = 1'b1;
                        status = ST_LEN_LOW;
                    end else if (c_length == HDR_SIZE) begin
                        o_emit = 1'b1;
                        status = crc_ok ? ST_VALID : ST_CRC_BAD;
                    end else if (i_eos) begin
                        o_emit = 1'b1;
                        status = ST_SHORT_DATA;
                    end
                end else begin
                    n_pos = p + 32'd1;
                    if (i_eos) begin
                        o_emit = 1'b1;
                        status = ST_SHORT_HDR;
                    end
                end
            end else begin
                // image body
                hdr_ok = 1'b1;
                n_crc  = crc_upd;
                n_pos  = p + 32'd1;
                if (p == c_length - 32'd1) begin
                    o_emit = 1'b1;
                    status = crc_ok ? ST_VALID : ST_CRC_BAD;
                end else if (i_eos) begin
                    o_emit = 1'b1;
                    status = ST_SHORT_DATA;
                end
            end
        end

        if (o_emit) begin
            n_phase = PH_DONE;
        end
    end

    // result fields
    always_comb begin
        o_result.status  = status;
        o_result.version = hdr_ok ? n_version : 16'd0;
        o_result.crc     = n_crc;
        o_result.length  = hdr_ok ? n_length : 32'd0;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_magic   <= '0;
            r_length  <= '0;
            r_hcrc    <= '0;
            r_version <= '0;
            r_crc     <= CRC_PRESET;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_magic   <= n_magic;
            r_length  <= n_length;
            r_hcrc    <= n_hcrc;
            r_version <= n_version;
            r_crc     <= n_crc;
        end
    end

endmodule

[rtl/core/firmware_image_crc_checker.sv]
// top level of the firmware image crc checker
//
//   channel   valid          stall          payload
//   in        i_in_valid     o_in_stall     i_data_byte, i_start_of_stream, i_end_of_stream
//   out       o_out_valid    i_out_stall    o_status, o_image_version, o_computed_crc,
//                                           o_image_length
//   cfg       i_cfg_wr_en    -              i_cfg_wr_data (skip_bytes)
//
// one byte per cycle while no stalled status holds the result register; a status
// leaves through the input register, then the result register; the byte-wide crc table sets the path
// reset clears the phase to idle and skip_bytes to zero
// the input stalls only while a status sits in the result register and is stalled
`timescale 1ns / 1ps

module firmware_image_crc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_start_of_stream,
    input  logic             i_end_of_stream,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fic_pkg::t_status o_status,
    output logic [15:0]      o_image_version,
    output logic [31:0]      o_computed_crc,
    output logic [31:0]      o_image_length
);
    import fic_pkg::*;

    logic        r_skip;
    logic [31:0] r_skip_bytes;
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_sos;
    logic        r_eos;
    logic        r_out_valid;
    t_result     r_out;
    logic        advance;
    logic        fire;
    logic        emit;
    t_result     result;

    // skip count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_bytes <= '0;
            r_skip       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_skip_bytes <= i_cfg_wr_data;
            r_skip       <= (i_cfg_wr_data != 32'd0);
        end
    end

    // handshake: the work stage moves when the result register is free or drains
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_data_byte;
            r_sos  <= i_start_of_stream;
            r_eos  <= i_end_of_stream;
        end
    end

    fic_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_byte),
        .i_sos        (r_sos),
        .i_eos        (r_eos),
        .i_skip_bytes (r_skip ? r_skip_bytes : 32'd0),
        .o_emit       (emit),
        .o_result     (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_image_version = r_out.version;
    assign o_computed_crc  = r_out.crc;
    assign o_image_length  = r_out.length;

endmodule

[rtl/core/fic_checker.sv]
// port-level checks for the firmware image crc checker, bound to the top level
`timescale 1ns / 1ps
`include "firmware_image_crc_checker_assert.svh"

module fic_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input fic_pkg::t_status o_status,
    input logic [15:0]      o_image_version,
    input logic [31:0]      o_computed_crc,
    input logic [31:0]      o_image_length
);
    import fic_pkg::*;

    // status codes stay within the defined set
    `FIC_ASSERT_NOW(a_status_range, o_out_valid, o_status == ST_VALID || o_status == ST_SHORT_HDR || o_status == ST_BAD_MAGIC || o_status == ST_LEN_LOW || o_status == ST_SHORT_DATA || o_status == ST_CRC_BAD, "status code out of range")

    // a cut-short header reports no header fields
    `FIC_ASSERT_NOW(a_short_hdr_zero, o_out_valid && o_status == ST_SHORT_HDR, o_image_version == 16'd0 && o_image_length == 32'd0, "short header with header fields")

    // input is held back only by a stalled pending status
    `FIC_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked result")

    // a stalled status request holds
    `FIC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_computed_crc) && $stable(o_image_length), "stalled result changed")

endmodule

bind firmware_image_crc_checker fic_checker u_fic_checker (.*);
